// File: hw/rtl/byte_run_length_encoder_core_assert.svh
// Assertion macros for the byte run-length encoder.
// Included by the top level; relies on clk and rst_n in the including scope.
`ifndef BYTE_RUN_LENGTH_ENCODER_CORE_ASSERT_SVH
`define BYTE_RUN_LENGTH_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define BRLE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, disabled while in reset.
`define BRLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// File: hw/rtl/brle_pkg.sv
// Shared types and constants of the byte run-length encoder.
// No dependencies; used by brle_out_if and all modules.
package brle_pkg;

    // Longest run in one pair by default.
    localparam int MAX_RUN_DEF = 255;

    // Output byte counter and capacity width.
    localparam int CAP_W = 24;
    localparam logic [CAP_W-1:0] CAP_RESET = '1;

    // Result queue geometry.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QLVL_W = $clog2(QDEPTH + 1);

    // Register decode: register index bit of paddr.
    localparam logic REG_CAPACITY = 1'b0;

    // One result item.
    typedef struct packed {
        logic [7:0]       run_count;
        logic [7:0]       run_value;
        logic             overflow_error;
        logic             job_done;
        logic [CAP_W-1:0] bytes_out;
    } brle_res_t;

    // Results produced by one item, first in res0.
    typedef struct packed {
        logic [1:0] cnt;
        brle_res_t  res1;
        brle_res_t  res0;
    } brle_push_t;

endpackage

// File: hw/rtl/brle_if.sv
// Valid/ready channel interfaces of the byte run-length encoder.
// Depends on brle_pkg for the counter width.
interface brle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface brle_out_if;
    logic                        valid;
    logic                        ready;
    logic [7:0]                  run_count;
    logic [7:0]                  run_value;
    logic                        overflow_error;
    logic                        job_done;
    logic [brle_pkg::CAP_W-1:0]  bytes_out;

    modport source (output valid, output run_count, output run_value,
                    output overflow_error, output job_done, output bytes_out,
                    input ready);
    modport sink (input valid, input run_count, input run_value,
                  input overflow_error, input job_done, input bytes_out,
                  output ready);
endinterface

// File: hw/rtl/brle_cfg.sv
// APB configuration register of the byte run-length encoder.
// Depends on brle_pkg; holds the per-job output capacity.
module brle_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [brle_pkg::CAP_W-1:0]  capacity
);
    import brle_pkg::*;

    logic [CAP_W-1:0] cap_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Capacity register, written in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (wr_en && (paddr[2] == REG_CAPACITY))
        begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    // Read decode; the low address bits are ignored.
    always_comb
    begin
        unique case (paddr[2])
            REG_CAPACITY: prdata = {{(32 - CAP_W){1'b0}}, cap_reg};
            default:      prdata = '0;
        endcase
    end

    assign capacity = cap_reg;

    // Byte lanes are not used by this register file.
    logic unused_low;
    assign unused_low = ^paddr[1:0];

endmodule

// File: hw/rtl/brle_enc.sv
// Run tracking and pair generation of the byte run-length encoder.
// Depends on brle_pkg; registers one input item and emits up to two results.
module brle_enc #(
    parameter int MAX_RUN = brle_pkg::MAX_RUN_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   data_byte,
    input  logic                         final_byte,
    input  logic [brle_pkg::CAP_W-1:0]   capacity,
    input  logic [brle_pkg::QLVL_W-1:0]  q_level,
    output brle_pkg::brle_push_t         push
);
    import brle_pkg::*;

    localparam logic [7:0] MaxRunW = 8'(MAX_RUN);
    localparam logic [QLVL_W-1:0] RoomLvl = QLVL_W'(QDEPTH - 2);

    // Input register stage.
    logic             stg_valid_reg;
    logic [7:0]       stg_byte_reg;
    logic             stg_last_reg;

    // Job state.
    logic [7:0]       run_byte_reg, run_byte_next;
    logic [7:0]       run_len_reg, run_len_next;
    logic [CAP_W-1:0] total_reg, total_next;
    logic             aborted_reg, aborted_next;

    logic             advance;
    brle_push_t       push_c;

    // The stage moves on when the result queue has room for two results.
    assign advance  = stg_valid_reg && (q_level <= RoomLvl);
    assign in_ready = !stg_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stg_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            stg_byte_reg <= data_byte;
            stg_last_reg <= final_byte;
        end
    end

    // Run update, capacity checks and result building for the staged item.
    always_comb
    begin
        logic [CAP_W:0] sum0;
        logic [CAP_W:0] sum1;
        logic           done;

        run_byte_next = run_byte_reg;
        run_len_next  = run_len_reg;
        total_next    = total_reg;
        aborted_next  = aborted_reg;
        push_c        = '0;
        done          = 1'b0;
        sum0          = {1'b0, total_reg} + (CAP_W + 1)'(2);
        sum1          = '0;

        if (aborted_reg)
        begin
            // Dropping the rest of an overflowed job.
            if (stg_last_reg)
            begin
                run_byte_next = '0;
                run_len_next  = '0;
                total_next    = '0;
                aborted_next  = 1'b0;
            end
            done = 1'b1;
        end
        else if (run_len_reg == 8'd0)
        begin
            run_byte_next = stg_byte_reg;
            run_len_next  = 8'd1;
        end
        else if ((stg_byte_reg != run_byte_reg) || (run_len_reg >= MaxRunW))
        begin
            push_c.cnt = 2'd1;
            if (sum0 > {1'b0, capacity})
            begin
                // Closed run does not fit: error result ends the job.
                push_c.res0.overflow_error = 1'b1;
                push_c.res0.job_done       = 1'b1;
                push_c.res0.bytes_out      = total_reg;
                if (stg_last_reg)
                begin
                    run_byte_next = '0;
                    run_len_next  = '0;
                    total_next    = '0;
                end
                else
                begin
                    aborted_next = 1'b1;
                end
                done = 1'b1;
            end
            else
            begin
                push_c.res0.run_count = run_len_reg;
                push_c.res0.run_value = run_byte_reg;
                push_c.res0.bytes_out = sum0[CAP_W-1:0];
                total_next            = sum0[CAP_W-1:0];
                run_byte_next         = stg_byte_reg;
                run_len_next          = 8'd1;
            end
        end
        else
        begin
            run_len_next = run_len_reg + 8'd1;
        end

        // Last byte of the job closes the open run.
        if (stg_last_reg && !done)
        begin
            sum1 = {1'b0, total_next} + (CAP_W + 1)'(2);
            if (push_c.cnt == 2'd1)
            begin
                push_c.res1.job_done = 1'b1;
                if (sum1 > {1'b0, capacity})
                begin
                    push_c.res1.overflow_error = 1'b1;
                    push_c.res1.bytes_out      = total_next;
                end
                else
                begin
                    push_c.res1.run_count = run_len_next;
                    push_c.res1.run_value = run_byte_next;
                    push_c.res1.bytes_out = sum1[CAP_W-1:0];
                end
                push_c.cnt = 2'd2;
            end
            else
            begin
                push_c.res0.job_done = 1'b1;
                if (sum1 > {1'b0, capacity})
                begin
                    push_c.res0.overflow_error = 1'b1;
                    push_c.res0.bytes_out      = total_next;
                end
                else
                begin
                    push_c.res0.run_count = run_len_next;
                    push_c.res0.run_value = run_byte_next;
                    push_c.res0.bytes_out = sum1[CAP_W-1:0];
                end
                push_c.cnt = 2'd1;
            end
            run_byte_next = '0;
            run_len_next  = '0;
            total_next    = '0;
            aborted_next  = 1'b0;
        end
    end

    // Job state registers update only when the staged item is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_byte_reg <= '0;
            run_len_reg  <= '0;
            total_reg    <= '0;
            aborted_reg  <= 1'b0;
        end
        else if (advance)
        begin
            run_byte_reg <= run_byte_next;
            run_len_reg  <= run_len_next;
            total_reg    <= total_next;
            aborted_reg  <= aborted_next;
        end
    end

    always_comb
    begin
        push = push_c;
        if (!advance)
        begin
            push.cnt = 2'd0;
        end
    end

endmodule

// File: hw/rtl/brle_fifo.sv
// Result queue of the byte run-length encoder.
// Depends on brle_pkg; takes up to two results per cycle, gives one.
module brle_fifo (
    input  logic                         clk,
    input  logic                         rst_n,
    input  brle_pkg::brle_push_t         push,
    input  logic                         pop,
    output logic                         not_empty,
    output brle_pkg::brle_res_t          head,
    output logic [brle_pkg::QLVL_W-1:0]  level
);
    import brle_pkg::*;

    brle_res_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QLVL_W-1:0]  level_reg;
    logic [QPTR_W-1:0]  wr_ptr_1;

    assign wr_ptr_1 = wr_ptr_reg + QPTR_W'(1);

    // Storage writes; the second result goes one slot after the first.
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.cnt == 2'd2)
        begin
            mem_reg[wr_ptr_1] <= push.res1;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push.cnt);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            level_reg <= level_reg + QLVL_W'(push.cnt) - QLVL_W'(pop);
        end
    end

    assign not_empty = (level_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign level     = level_reg;

endmodule

// File: hw/rtl/byte_run_length_encoder_core.sv
// Byte run-length encoder: turns a byte stream into (count, value) pairs.
// Channels: in_ch takes one byte per item with final_byte marking the last
// byte of a job; out_ch gives result items (run_count, run_value,
// overflow_error, job_done, bytes_out). Both use valid/ready, an item moves
// when both are high. The APB port holds output_capacity at address 0.
// An accepted item waits in the input register; its results are then written
// to the result queue. Throughput: one byte per cycle while the queue has
// room; an item that closes a run and ends the job yields two results, which
// drain at one per cycle through a four-entry result queue while out_ch.ready
// is high. The input register takes a new item whenever the queue has room
// for two results. A stalled receiver backs up the queue, after which
// in_ch.ready drops; nothing is lost. Reset clears run, counter and abort
// state, empties the queue and sets the capacity to its maximum.
// Depends on brle_pkg, brle_if, brle_cfg, brle_enc and brle_fifo.
`include "byte_run_length_encoder_core_assert.svh"

module byte_run_length_encoder_core #(
    parameter int MAX_RUN = brle_pkg::MAX_RUN_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    brle_in_if.sink      in_ch,
    brle_out_if.source   out_ch,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import brle_pkg::*;

    logic [CAP_W-1:0]   capacity;
    logic [QLVL_W-1:0]  q_level;
    brle_push_t         push;
    brle_res_t          head;
    logic               not_empty;
    logic               pop;

    // Configuration register.
    brle_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    // Run tracking and pair generation.
    brle_enc #(
        .MAX_RUN (MAX_RUN)
    ) u_enc (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .data_byte  (in_ch.data_byte),
        .final_byte (in_ch.final_byte),
        .capacity   (capacity),
        .q_level    (q_level),
        .push       (push)
    );

    // Result queue toward the output channel.
    brle_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head),
        .level     (q_level)
    );

    assign pop                   = not_empty && out_ch.ready;
    assign out_ch.valid          = not_empty;
    assign out_ch.run_count      = head.run_count;
    assign out_ch.run_value      = head.run_value;
    assign out_ch.overflow_error = head.overflow_error;
    assign out_ch.job_done       = head.job_done;
    assign out_ch.bytes_out      = head.bytes_out;

    // The queue never overfills.
    `BRLE_ASSERT_IMPL(a_queue_bound, 1'b1, q_level <= QLVL_W'(QDEPTH))
    // A double push only happens with room for both results.
    `BRLE_ASSERT_IMPL(a_push_room, push.cnt == 2'd2, q_level <= QLVL_W'(QDEPTH - 2))
    // An error result ends its job and carries no pair.
    `BRLE_ASSERT_IMPL(a_err_last, out_ch.valid && out_ch.overflow_error,
                      out_ch.job_done && (out_ch.run_count == 8'd0))
    // A regular pair always has a nonzero run length.
    `BRLE_ASSERT_IMPL(a_pair_len, out_ch.valid && !out_ch.overflow_error,
                      out_ch.run_count != 8'd0)

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the byte run-length encoder core.
// Depends on brle_pkg, the brle_in_if/brle_out_if channel interfaces and the RTL top level.
`timescale 1ns / 100ps

module testbench;
    import brle_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 10;
    localparam int LONG_HOLD = 200;
    localparam logic [2:0] CAP_ADDR = {REG_CAPACITY, 2'b00};
    localparam logic [CAP_W-1:0] CAP_MAX = '1;
    localparam logic [7:0] MAX_RUN_W = 8'(MAX_RUN_DEF);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } raw_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    brle_in_if in_ch ();
    brle_out_if out_ch ();

    byte_run_length_encoder_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Raw bytes waiting to be offered, and the run pairs the encoder owes us.
    raw_item_t raw_pending[$];
    brle_res_t pairs_owed[$];

    // Encoder state as the testbench sees it.
    logic [CAP_W-1:0] capacity;
    logic [7:0] open_byte;
    logic [7:0] open_len;
    logic [CAP_W-1:0] job_bytes;
    logic dropping;

    int sender_gap_pct = 0;
    int receiver_gap_pct = 0;
    logic hold_off_req = 1'b0;
    int mismatch_count = 0;
    int cycle_count = 0;

    always #1 clk = ~clk;

    // Drop the open job: no run, no output bytes, no abort.
    task automatic clear_job();
        open_byte = '0;
        open_len = '0;
        job_bytes = '0;
        dropping = 1'b0;
    endtask

    // Close the open run as a pair, or as an overflow error if it does not fit.
    task automatic close_run(input logic last_pair, output logic fits);
        brle_res_t pair;
        logic [CAP_W:0] next_total;
        next_total = {1'b0, job_bytes} + (CAP_W + 1)'(2);
        if (next_total > {1'b0, capacity})
        begin
            pair.run_count = '0;
            pair.run_value = '0;
            pair.overflow_error = 1'b1;
            pair.job_done = 1'b1;
            pair.bytes_out = job_bytes;
            fits = 1'b0;
        end
        else
        begin
            job_bytes = next_total[CAP_W-1:0];
            pair.run_count = open_len;
            pair.run_value = open_byte;
            pair.overflow_error = 1'b0;
            pair.job_done = last_pair;
            pair.bytes_out = job_bytes;
            fits = 1'b1;
        end
        pairs_owed.push_back(pair);
    endtask

    // Advance the encoder state by one accepted byte and queue the pairs it yields.
    task automatic encode_byte(input logic [7:0] data, input logic last);
        logic fits;
        if (dropping)
        begin
            if (last)
                clear_job();
            return;
        end
        if (open_len == 8'd0)
        begin
            open_byte = data;
            open_len = 8'd1;
        end
        else if (data != open_byte || open_len >= MAX_RUN_W)
        begin
            close_run(1'b0, fits);
            if (!fits)
            begin
                if (last)
                    clear_job();
                else
                    dropping = 1'b1;
                return;
            end
            open_byte = data;
            open_len = 8'd1;
        end
        else
        begin
            open_len = open_len + 8'd1;
        end
        if (last)
        begin
            close_run(1'b1, fits);
            clear_job();
        end
    endtask

    // Byte driver: predicts on acceptance, then offers the next pending byte.
    always @(posedge clk)
    begin : drive_bytes
        raw_item_t next_item;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                encode_byte(in_ch.data_byte, in_ch.final_byte);
            if (!in_ch.valid || in_ch.ready)
            begin
                if (raw_pending.size() != 0 && $urandom_range(99) >= sender_gap_pct)
                begin
                    next_item = raw_pending.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.data_byte <= next_item.data_byte;
                    in_ch.final_byte <= next_item.final_byte;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: one long hold-off on request, random stalls otherwise.
    always @(posedge clk)
    begin : drive_ready
        int hold_left;
        logic hold_taken;
        if (!rst_n)
        begin
            hold_left = 0;
            hold_taken = 1'b0;
            out_ch.ready <= 1'b0;
        end
        else if (hold_off_req && !hold_taken)
        begin
            hold_left = LONG_HOLD;
            hold_taken = 1'b1;
            out_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= receiver_gap_pct);
        end
    end

    task automatic check_field(input string field, input logic [CAP_W-1:0] want,
                               input logic [CAP_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // Pair monitor: every accepted result is matched against the oldest pair owed.
    always @(posedge clk)
    begin : watch_pairs
        brle_res_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pairs_owed.size() == 0)
            begin
                $display("%0t: extra result, expected none, actual %0d %0d %0b %0b %0d",
                         $time, out_ch.run_count, out_ch.run_value, out_ch.overflow_error,
                         out_ch.job_done, out_ch.bytes_out);
                mismatch_count++;
            end
            else
            begin
                want = pairs_owed.pop_front();
                check_field("run_count", CAP_W'(want.run_count), CAP_W'(out_ch.run_count));
                check_field("run_value", CAP_W'(want.run_value), CAP_W'(out_ch.run_value));
                check_field("overflow_error", CAP_W'(want.overflow_error),
                            CAP_W'(out_ch.overflow_error));
                check_field("job_done", CAP_W'(want.job_done), CAP_W'(out_ch.job_done));
                check_field("bytes_out", want.bytes_out, out_ch.bytes_out);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic add_byte(input logic [7:0] data, input logic last);
        raw_pending.push_back('{data_byte: data, final_byte: last});
    endtask

    task automatic queue_run(input logic [7:0] value, input int len, input logic ends_job);
        for (int i = 0; i < len; i++)
            add_byte(value, ends_job && (i == len - 1));
    endtask

    // One job of random runs; values come half from a small alphabet so that runs merge.
    task automatic queue_job(input int runs, input int longest, output int added);
        logic [7:0] value;
        int len;
        added = 0;
        for (int r = 0; r < runs; r++)
        begin
            value = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(2) * 8'h55);
            len = ($urandom_range(19) == 0) ? $urandom_range(1, longest) : $urandom_range(1, 4);
            queue_run(value, len, r == runs - 1);
            added += len;
        end
    endtask

    task automatic queue_jobs(input int budget, input int max_runs, input int longest);
        int added;
        int job_len;
        added = 0;
        while (added < budget)
        begin
            queue_job($urandom_range(1, max_runs), longest, job_len);
            added += job_len;
        end
    endtask

    // APB write: setup cycle, then access until pready.
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CAP_ADDR;
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        capacity = value;
    endtask

    // Wait until every byte is taken and every pair is back, then let the pipe settle.
    task automatic wait_drained();
        @(negedge clk);
        while (raw_pending.size() != 0 || in_ch.valid || pairs_owed.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.final_byte = 1'b0;
        out_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        capacity = CAP_MAX;
        clear_job();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Sender idles a third of the time, receiver most of the time.
        sender_gap_pct = 33;
        receiver_gap_pct = 76;

        // Full capacity: single-byte job, break together with last, alternating extremes.
        write_capacity(CAP_MAX);
        add_byte(8'h00, 1'b1);
        queue_run(8'hFF, 2, 1'b0);
        add_byte(8'hAA, 1'b1);
        add_byte(8'h01, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'h7F, 1'b1);
        queue_run(8'hAA, 2, 1'b1);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b1);
        queue_jobs(280, 6, 300);
        wait_drained();

        // No room at all: every job overflows on its first pair; a dropped job's tail is silent.
        write_capacity('0);
        add_byte(8'h12, 1'b1);
        queue_run(8'h34, 2, 1'b0);
        queue_run(8'h56, 2, 1'b1);
        add_byte(8'h03, 1'b0);
        add_byte(8'h04, 1'b1);
        queue_jobs(40, 4, 6);
        wait_drained();

        write_capacity(24'd1);
        queue_jobs(40, 4, 6);
        wait_drained();

        // Now the receiver idles a third of the time, the sender most of the time.
        sender_gap_pct = 76;
        receiver_gap_pct = 33;

        write_capacity(24'd8);
        queue_jobs(250, 6, 12);
        wait_drained();

        // Exactly one pair fits: the last pair of a two-run job overflows.
        write_capacity(24'd2);
        add_byte(8'h01, 1'b0);
        add_byte(8'h02, 1'b1);
        queue_jobs(60, 3, 6);
        wait_drained();

        // No idling; the receiver holds off long enough to back up the input.
        sender_gap_pct = 0;
        receiver_gap_pct = 0;

        write_capacity(24'd40);
        queue_jobs(250, 8, 20);
        hold_off_req = 1'b1;
        wait_drained();

        // Runs at and just past the maximum run length.
        write_capacity(CAP_MAX - 24'd1);
        queue_run(8'h77, MAX_RUN_DEF, 1'b1);
        queue_run(8'h77, MAX_RUN_DEF + 1, 1'b1);
        queue_jobs(20, 6, 20);
        wait_drained();

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
